/* rtl/qcbp_pkg.sv */
`default_nettype none
package qcbp_pkg;
  localparam int CoordW = 16;
  localparam int BandW = 3;
  localparam int NumBands = 7;
  localparam int OutCap = 64;
  localparam int SlotW = 6;
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegLevelCount = 3'd0;

  typedef struct packed {
    logic load;
    logic edge_init;
    logic lvl_eval;
    logic div_start;
    logic lerp;
    logic emit;
  } qcbp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic crossing;
    logic lvl_last;
    logic edge_last;
    logic emit_done;
    logic push_busy;
  } qcbp_sts_t;
endpackage
`default_nettype wire

/* rtl/quad_contour_band_points.sv */
`default_nettype none
// Contour band points for one quad face.
// Issue a face by holding the twelve corner fields and raising start while
// busy is low; the face is taken on that edge. Levels are written through
// cfg_we/cfg_index/cfg_data while busy is low: index 0 is level_count,
// indexes 1..7 are levels 0..6.
// The face is walked edge by edge and level by level; every crossing runs a
// 48-step bit-serial divider, and the walk also holds after each level step
// that stores points until those points are written. One face at a time.
// Points leave one per cycle, marked by strobe, grouped by ascending band;
// band_last and face_last mark the ends. A face with no points gives a single
// beat with empty_face set. At most 64 points per face are sent.
// The receiver cannot stall: each beat is shown for exactly one cycle.
// Synchronous reset sets level_count to 2 and all levels to 0, and returns
// the block to idle.
module quad_contour_band_points #(
  parameter int MAX_LEVELS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic signed [15:0] corner0_x,
  input  wire logic signed [15:0] corner0_y,
  input  wire logic signed [15:0] corner0_val,
  input  wire logic signed [15:0] corner1_x,
  input  wire logic signed [15:0] corner1_y,
  input  wire logic signed [15:0] corner1_val,
  input  wire logic signed [15:0] corner2_x,
  input  wire logic signed [15:0] corner2_y,
  input  wire logic signed [15:0] corner2_val,
  input  wire logic signed [15:0] corner3_x,
  input  wire logic signed [15:0] corner3_y,
  input  wire logic signed [15:0] corner3_val,
  output logic             strobe,
  output logic [2:0]       band,
  output logic signed [15:0] point_x,
  output logic signed [15:0] point_y,
  output logic             band_last,
  output logic             face_last,
  output logic             empty_face
);
  import qcbp_pkg::*;

  logic [2:0] level_count;
  logic signed [15:0] levels [7];
  logic signed [MAX_LEVELS*16-1:0] lv_flat;
  qcbp_cmd_t cmd;
  qcbp_sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= 3'd2;
      for (int i = 0; i < 7; i++) begin
        levels[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == RegLevelCount) begin
        level_count <= cfg_data[2:0];
      end else begin
        levels[cfg_index - 3'd1] <= cfg_data;
      end
    end
  end

  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_flat
    assign lv_flat[g*16 +: 16] = levels[g];
  end

  qcbp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  qcbp_datapath #(.MaxLevels(MAX_LEVELS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_count  (level_count),
    .cfg_levels (lv_flat),
    .corners    ({corner3_val, corner3_y, corner3_x, corner2_val, corner2_y, corner2_x,
                  corner1_val, corner1_y, corner1_x, corner0_val, corner0_y, corner0_x}),
    .strobe     (strobe),
    .band       (band),
    .point_x    (point_x),
    .point_y    (point_y),
    .band_last  (band_last),
    .face_last  (face_last),
    .empty_face (empty_face)
  );
endmodule
`default_nettype wire

/* rtl/qcbp_ram.sv */
`default_nettype none
module qcbp_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/qcbp_ctrl.sv */
`default_nettype none
module qcbp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire qcbp_pkg::qcbp_sts_t sts,
  output qcbp_pkg::qcbp_cmd_t cmd
);
  import qcbp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EDGE = 7'b0000010,
    S_LVL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_LERP = 7'b0010000,
    S_EMIT = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.edge_init = 1'b1;
        state_next = S_LVL;
      end
      S_LVL: begin
        // hold while earlier points are still being stored
        if (!sts.push_busy) begin
          cmd.lvl_eval = 1'b1;
          if (sts.crossing) begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end else if (sts.lvl_last) begin
            state_next = sts.edge_last ? S_WAIT : S_EDGE;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_LERP;
        end
      end
      S_LERP: begin
        cmd.lerp = 1'b1;
        if (sts.lvl_last) begin
          state_next = sts.edge_last ? S_WAIT : S_EDGE;
        end else begin
          state_next = S_LVL;
        end
      end
      S_WAIT: begin
        if (!sts.push_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

/* rtl/qcbp_datapath.sv */
`default_nettype none
module qcbp_datapath #(
  parameter int MaxLevels = 7
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire qcbp_pkg::qcbp_cmd_t               cmd,
  output qcbp_pkg::qcbp_sts_t                    sts,
  input  wire logic [2:0]                        cfg_count,
  input  wire logic signed [MaxLevels*16-1:0]    cfg_levels,
  input  wire logic signed [12*16-1:0]           corners,
  output logic                                   strobe,
  output logic [qcbp_pkg::BandW-1:0]             band,
  output logic signed [15:0]                     point_x,
  output logic signed [15:0]                     point_y,
  output logic                                   band_last,
  output logic                                   face_last,
  output logic                                   empty_face
);
  import qcbp_pkg::*;

  localparam int LvlW = 3;
  localparam int CntW = SlotW + 1;
  localparam int TotW = CntW + 2;

  logic signed [15:0] cx [4];
  logic signed [15:0] cy [4];
  logic signed [15:0] cv [4];
  logic signed [15:0] lvl [MaxLevels];
  logic [LvlW-1:0] n;
  logic [1:0] edge_i;
  logic [LvlW-1:0] k;
  logic desc;
  logic signed [15:0] z0, z1, zmin, zmax, sx, sy, tx, ty;
  logic [LvlW-1:0] li;
  logic signed [15:0] lv;
  logic [CntW-1:0] band_n [NumBands];

  // per-face store of pushed points: one row per band
  logic            ram_we;
  logic [BandW+SlotW-1:0] ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;
  logic            push_a, push_b;
  logic [BandW-1:0] pend_band;
  logic            pend_valid;
  logic signed [15:0] pend_x, pend_y;

  for (genvar g = 0; g < MaxLevels; g++) begin : g_lvl
    assign lvl[g] = cfg_levels[g*16 +: 16];
  end

  always_comb begin
    li = desc ? LvlW'(n - LvlW'(1) - k) : k;
    lv = lvl[li];
  end

  logic corner_between, corner_on, crossing, lvl_ok;
  logic signed [15:0] lv_up;
  always_comb begin
    lvl_ok = (k < n);
    lv_up = (li + LvlW'(1) < n && li < LvlW'(MaxLevels - 1)) ? lvl[li + LvlW'(1)] : 16'sd0;
    corner_between = lvl_ok && (li + LvlW'(1) < n) && (lv < z0) && (z0 < lv_up);
    corner_on = lvl_ok && !corner_between && (lv == z0);
    crossing = lvl_ok && (zmin < lv) && (lv < zmax);
  end

  // divider: f = |num|<<16 / |den|, restoring, one bit per cycle
  logic [16:0] d_den;
  logic [32:0] d_rem;
  logic [31:0] d_quo;
  logic [5:0]  d_cnt;
  logic        d_run;
  logic [16:0] an;
  logic [47:0] d_num;

  always_comb begin
    an = (lv >= z0) ? 17'(lv - z0) : 17'(z0 - lv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_run <= 1'b0;
    end else if (cmd.div_start) begin
      d_run <= 1'b1;
      d_cnt <= 6'd0;
      d_rem <= '0;
      d_num <= {15'd0, an, 16'd0};
      d_den <= (z1 >= z0) ? 17'(z1 - z0) : 17'(z0 - z1);
      d_quo <= '0;
    end else if (d_run) begin
      d_cnt <= d_cnt + 6'd1;
      d_num <= {d_num[46:0], 1'b0};
      if ({d_rem[31:0], d_num[47]} >= {16'd0, d_den}) begin
        d_rem <= {d_rem[31:0], d_num[47]} - {16'd0, d_den};
        d_quo <= {d_quo[30:0], 1'b1};
      end else begin
        d_rem <= {d_rem[31:0], d_num[47]};
        d_quo <= {d_quo[30:0], 1'b0};
      end
      if (d_cnt == 6'd47) begin
        d_run <= 1'b0;
      end
    end
  end
  logic div_done;
  assign div_done = d_run && d_cnt == 6'd47;

  // interpolation once quotient registered
  logic [31:0] f;
  logic div_fin;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_fin <= 1'b0;
    end else begin
      div_fin <= div_done;
    end
  end
  always_comb begin
    f = d_quo;
  end

  function automatic logic signed [15:0] lerp_c(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic [31:0] ff);
    logic signed [17:0] d;
    logic signed [50:0] p;
    logic signed [34:0] q;
    begin
      d = 18'(b) - 18'(a);
      p = 51'(d) * $signed({1'b0, 18'(ff)});
      q = 35'(p >>> 16);
      lerp_c = 16'(35'(a) + q);
    end
  endfunction

  logic [BandW-1:0] qband [2];
  logic             qv [2];
  logic signed [15:0] qx, qy;

  assign sts.div_done = div_fin;
  assign sts.crossing = crossing && !d_run;
  assign sts.lvl_last = (k == LvlW'(n - LvlW'(1))) || (n == '0);
  assign sts.edge_last = (edge_i == 2'd3);
  assign sts.push_busy = qv[0] || qv[1] || pend_valid;

  // emission
  logic [BandW-1:0] e_band;
  logic [CntW-1:0]  e_j;
  logic [CntW-1:0]  e_total, e_emitted;
  logic             e_run, e_first, e_empty;
  logic             rd_valid;
  logic [BandW-1:0] rd_band;
  logic             rd_blast, rd_flast;
  logic [TotW-1:0]  total;

  always_comb begin
    total = '0;
    for (int b = 0; b < NumBands; b++) begin
      total = total + TotW'(band_n[b]);
    end
  end

  // pushes: two-slot sequence, second push on the cycle after the first
  logic signed [15:0] px, py;
  always_comb begin
    push_a = 1'b0;
    push_b = 1'b0;
    px = sx;
    py = sy;
    if (cmd.lvl_eval && !d_run && (corner_between || corner_on)) begin
      push_a = 1'b1;
      push_b = corner_on;
    end else if (cmd.lerp) begin
      push_a = 1'b1;
      push_b = 1'b1;
      px = lerp_c(sx, tx, f);
      py = lerp_c(sy, ty, f);
    end
  end

  // corner pushes come before crossings of the same level: the crossing
  // uses a separate cycle (lerp), and pending second pushes drain first.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = {pend_x, pend_y};
    if (pend_valid && band_n[pend_band] < CntW'(OutCap)) begin
      ram_we = 1'b1;
      ram_waddr = {pend_band, band_n[pend_band][SlotW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      qv[0] <= 1'b0;
      qv[1] <= 1'b0;
    end else begin
      if (push_a) begin
        qv[0] <= 1'b1;
        qband[0] <= BandW'(li);
        qv[1] <= push_b && li != '0;
        qband[1] <= BandW'(li - LvlW'(1));
        qx <= px;
        qy <= py;
      end else if (qv[0]) begin
        qv[0] <= qv[1];
        qband[0] <= qband[1];
        qv[1] <= 1'b0;
      end
      pend_valid <= qv[0];
      pend_band <= qband[0];
      pend_x <= qx;
      pend_y <= qy;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 4; i++) begin
        cx[i] <= corners[(3*i)*16 +: 16];
        cy[i] <= corners[(3*i+1)*16 +: 16];
        cv[i] <= corners[(3*i+2)*16 +: 16];
      end
      n <= (cfg_count > LvlW'(MaxLevels)) ? LvlW'(MaxLevels) : cfg_count;
      edge_i <= 2'd3;
    end
    if (cmd.edge_init) begin
      edge_i <= edge_i + 2'd1;
      k <= '0;
      z0 <= cv[edge_i + 2'd1];
      z1 <= cv[edge_i + 2'd2];
      desc <= cv[edge_i + 2'd1] > cv[edge_i + 2'd2];
      zmin <= (cv[edge_i + 2'd1] < cv[edge_i + 2'd2]) ? cv[edge_i + 2'd1] : cv[edge_i + 2'd2];
      zmax <= (cv[edge_i + 2'd1] < cv[edge_i + 2'd2]) ? cv[edge_i + 2'd2] : cv[edge_i + 2'd1];
      sx <= cx[edge_i + 2'd1];
      sy <= cy[edge_i + 2'd1];
      tx <= cx[edge_i + 2'd2];
      ty <= cy[edge_i + 2'd2];
    end
    if ((cmd.lvl_eval && !crossing) || cmd.lerp) begin
      k <= k + LvlW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      for (int b = 0; b < NumBands; b++) begin
        band_n[b] <= '0;
      end
    end else if (ram_we) begin
      band_n[pend_band] <= band_n[pend_band] + CntW'(1);
    end
  end

  qcbp_ram #(.Width(32), .Depth(NumBands * OutCap)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // emission walker: skip empty bands, read one point per cycle
  logic [BandW-1:0] nb;
  logic             nb_found;
  always_comb begin
    nb = e_band;
    nb_found = 1'b0;
    for (int b = NumBands - 1; b >= 0; b--) begin
      if (BandW'(b) > e_band && band_n[b] != '0) begin
        nb = BandW'(b);
        nb_found = 1'b1;
      end
    end
  end

  logic [BandW-1:0] fb;
  always_comb begin
    fb = '0;
    for (int b = NumBands - 1; b >= 0; b--) begin
      if (band_n[b] != '0) begin
        fb = BandW'(b);
      end
    end
  end

  logic go;
  assign go = cmd.emit && e_run;
  assign ram_raddr = {e_band, e_j[SlotW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_run <= 1'b0;
      e_first <= 1'b1;
      rd_valid <= 1'b0;
      strobe <= 1'b0;
      e_empty <= 1'b0;
    end else begin
      rd_valid <= go;
      e_empty <= cmd.emit && e_first && (total == '0);
      strobe <= rd_valid || e_empty;
      if (cmd.load) begin
        e_first <= 1'b1;
      end else if (cmd.emit && e_first) begin
        e_first <= 1'b0;
        if (total != '0) begin
          e_run <= 1'b1;
          e_band <= fb;
          e_j <= '0;
          e_emitted <= '0;
          e_total <= (total > TotW'(OutCap)) ? CntW'(OutCap) : CntW'(total);
        end
      end else if (go) begin
        rd_band <= e_band;
        rd_flast <= (e_emitted + CntW'(1) == e_total);
        rd_blast <= (e_j + CntW'(1) == band_n[e_band]) || (e_emitted + CntW'(1) == e_total);
        e_emitted <= e_emitted + CntW'(1);
        if (e_emitted + CntW'(1) == e_total) begin
          e_run <= 1'b0;
        end
        if (e_j + CntW'(1) == band_n[e_band] && nb_found) begin
          e_band <= nb;
          e_j <= '0;
        end else begin
          e_j <= e_j + CntW'(1);
        end
      end
    end
  end

  logic e_done_r;
  always_ff @(posedge clk) begin
    if (rst) begin
      e_done_r <= 1'b0;
    end else begin
      e_done_r <= (rd_valid && rd_flast) || e_empty;
    end
  end
  assign sts.emit_done = e_done_r;

  always_ff @(posedge clk) begin
    band <= rd_valid ? rd_band : '0;
    point_x <= rd_valid ? $signed(ram_rdata[31:16]) : 16'sd0;
    point_y <= rd_valid ? $signed(ram_rdata[15:0]) : 16'sd0;
    band_last <= rd_valid && rd_blast;
    face_last <= rd_valid && rd_flast;
    empty_face <= !rd_valid && e_empty;
  end
endmodule
`default_nettype wire
